// File: hdl/assert_macros.svh
// Assertion macros for the voice checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("voice assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("voice forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: hdl/pva_pkg.sv
// Types, constants and helper functions for the pulse voice
package pva_pkg;

    localparam int PULSE_AMPLITUDE_DEF = 8192;
    localparam int DUTY_SWING_DEF      = 1073741824;
    localparam int LFO_STEP_DEF        = 37086;

    localparam int REG_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam logic [REG_W-1:0] FULL_SCALE = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] phase_step;
    } item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               active;
    } result_t;

    typedef struct packed {
        logic [REG_W-1:0] attack_step;
        logic [REG_W-1:0] decay_step;
        logic [REG_W-1:0] sustain_level;
        logic [REG_W-1:0] release_step;
    } cfg_t;

    typedef struct packed {
        logic             note_on;
        logic             note_off;
        logic             tick;
    } env_cmd_t;

    typedef struct packed {
        logic             sounding;
        logic             active_next;
        logic [REG_W-1:0] level;
        logic [REG_W-1:0] env_out;
    } env_stat_t;

    // parabolic half sine magnitude, Q15 with 32768 as one
    function automatic logic [15:0] lfo_mag(input logic [31:0] phase);
        logic [14:0] h;
        logic [15:0] hc;
        logic [30:0] prod;
        h    = phase[30:16];
        hc   = 16'h8000 - {1'b0, h};
        prod = 31'(h * hc);
        return prod[28:13];
    endfunction

endpackage

// File: hdl/pva_env.sv
// Linear ADSR envelope: stage, level and release step registers
module pva_env import pva_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  env_cmd_t  cmd,
    output env_stat_t stat
);

    stage_t           stage_reg, stage_next;
    logic [REG_W-1:0] level_reg, level_next;
    logic [REG_W-1:0] drop_reg, drop_next;
    logic [REG_W-1:0] env_val;
    logic [15:0]      attack_sum;
    logic [15:0]      decay_floor;

    assign attack_sum  = {1'b0, level_reg} + {1'b0, cfg.attack_step};
    assign decay_floor = {1'b0, cfg.sustain_level} + {1'b0, cfg.decay_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            level_reg <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            level_reg <= level_next;
            drop_reg  <= drop_next;
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        level_next = level_reg;
        drop_next  = drop_reg;
        env_val    = '0;
        if (cmd.note_on)
        begin
            drop_next = '0;
            if (cfg.attack_step != '0)
            begin
                level_next = '0;
                stage_next = ST_ATTACK;
            end
            else
            begin
                level_next = FULL_SCALE;
                stage_next = ST_DECAY;
            end
        end
        else if (cmd.note_off)
        begin
            if (stage_reg inside {ST_ATTACK, ST_DECAY, ST_SUSTAIN})
            begin
                if (cfg.release_step == '0 || cfg.sustain_level == '0)
                begin
                    level_next = '0;
                    stage_next = ST_IDLE;
                end
                else
                begin
                    level_next = cfg.sustain_level;
                    drop_next  = cfg.release_step;
                    stage_next = ST_RELEASE;
                end
            end
        end
        else if (cmd.tick)
        begin
            case (stage_reg)
                ST_ATTACK:
                begin
                    if (cfg.attack_step == '0)
                    begin
                        level_next = FULL_SCALE;
                        stage_next = ST_DECAY;
                        env_val    = FULL_SCALE;
                    end
                    else
                    begin
                        env_val = level_reg;
                        if (attack_sum >= {1'b0, FULL_SCALE})
                        begin
                            level_next = FULL_SCALE;
                            stage_next = ST_DECAY;
                        end
                        else
                        begin
                            level_next = attack_sum[REG_W-1:0];
                        end
                    end
                end
                ST_DECAY:
                begin
                    if (cfg.decay_step == '0 || {1'b0, level_reg} <= decay_floor)
                    begin
                        level_next = cfg.sustain_level;
                        stage_next = ST_SUSTAIN;
                    end
                    else
                    begin
                        level_next = level_reg - cfg.decay_step;
                    end
                    env_val = level_next;
                end
                ST_SUSTAIN:
                begin
                    env_val = level_reg;
                end
                ST_RELEASE:
                begin
                    env_val = level_reg;
                    if (level_reg < drop_reg)
                    begin
                        level_next = '0;
                        stage_next = ST_IDLE;
                    end
                    else
                    begin
                        level_next = level_reg - drop_reg;
                    end
                end
                default:
                begin
                    stage_next = ST_IDLE;
                end
            endcase
        end
    end

    assign stat.sounding    = (stage_reg != ST_IDLE);
    assign stat.active_next = (stage_next != ST_IDLE);
    assign stat.level       = level_reg;
    assign stat.env_out     = env_val;

endmodule

// File: hdl/pva_lfo.sv
// Duty LFO with one tick of lookahead and the pulse threshold compare
module pva_lfo import pva_pkg::*; #(
    parameter int DUTY_SWING = DUTY_SWING_DEF,
    parameter int LFO_STEP   = LFO_STEP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic        advance,
    input  logic [31:0] osc_phase,
    output logic        pulse_high
);

    localparam logic [31:0] STEP_BITS = 32'(LFO_STEP);
    localparam logic [30:0] DUTY_BITS = 31'(DUTY_SWING);
    localparam logic [15:0] MAG_FIRST = lfo_mag(STEP_BITS);
    localparam logic [32:0] HALF      = 33'h0_8000_0000;

    logic [31:0] lfo_reg, lfo_next;
    logic [15:0] mag_reg;
    logic [46:0] duty_prod;
    logic [31:0] duty;
    logic [32:0] thresh;

    // lfo_reg holds the phase the coming tick uses, mag_reg its magnitude
    assign lfo_next = lfo_reg + STEP_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_reg <= STEP_BITS;
            mag_reg <= MAG_FIRST;
        end
        else if (restart)
        begin
            lfo_reg <= STEP_BITS;
            mag_reg <= MAG_FIRST;
        end
        else if (advance)
        begin
            lfo_reg <= lfo_next;
            mag_reg <= lfo_mag(lfo_next);
        end
    end

    assign duty_prod  = 47'(mag_reg * DUTY_BITS);
    assign duty       = duty_prod[46:15];
    assign thresh     = lfo_reg[31] ? (HALF + {1'b0, duty}) : (HALF - {1'b0, duty});
    assign pulse_high = ({1'b0, osc_phase} < thresh);

endmodule

// File: hdl/pva_mix.sv
// Envelope scaling, pulse sign and saturation of the output sample
module pva_mix import pva_pkg::*; #(
    parameter int PULSE_AMPLITUDE = PULSE_AMPLITUDE_DEF
) (
    input  logic               pulse_high,
    input  logic [REG_W-1:0]   env,
    output logic signed [15:0] sample
);

    localparam logic [REG_W-1:0] AMP_BITS = REG_W'(PULSE_AMPLITUDE);
    localparam logic [16:0]      AMP4     = {AMP_BITS, 2'b00};

    logic [31:0]        prod;
    logic [16:0]        mag;
    logic signed [17:0] val;

    assign prod = 32'(AMP4 * env);
    assign mag  = prod[31:15];
    assign val  = pulse_high ? $signed({1'b0, mag}) : -$signed({1'b0, mag});

    always_comb
    begin
        if (val > 18'sd32767)
        begin
            sample = 16'sh7FFF;
        end
        else if (val < -18'sd32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = val[15:0];
        end
    end

endmodule

// File: hdl/pwm_pulse_voice_adsr.sv
// Pulse voice top: handshake, oscillator, config registers and result register
// A tick word gives its result word in the cycle after it is accepted.
// Throughput: one word per cycle unless an untaken result is held; the single result register parts the channels.
// Note on and note off words change state only and give no result.
// Reset (rst_n low, asynchronous) clears all state but the result data; config takes its reset values.
`include "assert_macros.svh"
module pwm_pulse_voice_adsr import pva_pkg::*; #(
    parameter int PULSE_AMPLITUDE = PULSE_AMPLITUDE_DEF,
    parameter int DUTY_SWING      = DUTY_SWING_DEF,
    parameter int LFO_STEP        = LFO_STEP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    cfg_t               cfg_reg;
    logic [31:0]        osc_reg;
    logic [31:0]        step_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               fire;
    logic               live_tick;
    logic               pulse_high;
    logic signed [15:0] sample_val;
    env_cmd_t           cmd;
    env_stat_t          stat;

    assign item_ready   = !out_valid_reg || result_ready;
    assign fire         = item_valid && item_ready;
    assign cmd.note_on  = fire && (item.op == OP_NOTE_ON);
    assign cmd.note_off = fire && (item.op == OP_NOTE_OFF);
    assign cmd.tick     = fire && (item.op == OP_TICK);
    assign live_tick    = cmd.tick && stat.sounding;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step   <= '0;
            cfg_reg.decay_step    <= '0;
            cfg_reg.sustain_level <= FULL_SCALE;
            cfg_reg.release_step  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK:  cfg_reg.attack_step   <= cfg_data;
                CFG_DECAY:   cfg_reg.decay_step    <= cfg_data;
                CFG_SUSTAIN: cfg_reg.sustain_level <= cfg_data;
                CFG_RELEASE: cfg_reg.release_step  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.note_on)
        begin
            osc_reg  <= '0;
            step_reg <= item.phase_step;
        end
        else if (live_tick)
        begin
            osc_reg <= osc_reg + step_reg;
        end
    end

    pva_env u_env (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .stat  (stat)
    );

    pva_lfo #(
        .DUTY_SWING (DUTY_SWING),
        .LFO_STEP   (LFO_STEP)
    ) u_lfo (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cmd.note_on),
        .advance    (live_tick),
        .osc_phase  (osc_reg),
        .pulse_high (pulse_high)
    );

    pva_mix #(
        .PULSE_AMPLITUDE (PULSE_AMPLITUDE)
    ) u_mix (
        .pulse_high (pulse_high),
        .env        (stat.env_out),
        .sample     (sample_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            out_reg.sample <= sample_val;
            out_reg.active <= stat.active_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_CLK(idle_tick_silent, clk, rst_n,
        (cmd.tick && !stat.sounding) |=> (result_valid && result.sample == 16'sd0
            && !result.active))
    `ASSERT_CLK(no_result_for_notes, clk, rst_n,
        (fire && item.op != OP_TICK) |=> !result_valid)
    `ASSERT_NEVER(idle_level_zero, clk, rst_n,
        !stat.sounding && stat.level != '0)

endmodule

// File: sim/tb_pwm_pulse_voice_adsr.sv
// Self-checking bench for the pulse voice: queued words, in-bench voice predictor, checked results
`timescale 1ns / 100ps
module tb_pwm_pulse_voice_adsr;
    import pva_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_WORDS = 1350;
    localparam int PHASES       = 10;
    localparam int REPORT_CAP   = 50;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_RELEASE + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
    localparam longint HALF_CYCLE = 64'h8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;

    item_t   pending_words[$];
    result_t expected_samples[$];
    int      words_queued = 0;
    int      words_taken = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    bit      item_fire = 1'b0;
    int      send_gap = 0;
    int      send_rush = 0;
    int      stall_left = 0;
    int      take_rush = 0;

    int unsigned atk_step, dec_step, sus_lvl, rel_step;
    logic [31:0] osc_acc, lfo_acc, osc_inc;
    int unsigned env, env_drop;
    stage_t      stage;

    pwm_pulse_voice_adsr DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit voice_step(input item_t w, output result_t r);
        int unsigned lvl;
        logic [15:0] lfo_top;
        logic [14:0] h;
        longint      s, d, amp;
        bit          high;
        r = '0;
        case (w.op)
            OP_NOTE_ON:
            begin
                osc_inc = w.phase_step;
                osc_acc = '0;
                lfo_acc = '0;
                env_drop = 0;
                if (atk_step != 0)
                begin
                    env = 0;
                    stage = ST_ATTACK;
                end
                else
                begin
                    env = FULL_SCALE;
                    stage = ST_DECAY;
                end
                return 1'b0;
            end
            OP_NOTE_OFF:
            begin
                if (stage == ST_ATTACK || stage == ST_DECAY || stage == ST_SUSTAIN)
                begin
                    if (rel_step == 0 || sus_lvl == 0)
                    begin
                        env = 0;
                        stage = ST_IDLE;
                    end
                    else
                    begin
                        env = sus_lvl;
                        env_drop = rel_step;
                        stage = ST_RELEASE;
                    end
                end
                return 1'b0;
            end
            OP_TICK:
            begin
                if (stage == ST_IDLE)
                    return 1'b1;
                lfo_acc = lfo_acc + LFO_STEP_DEF;
                lfo_top = lfo_acc[31:16];
                h = lfo_top[14:0];
                s = (longint'(h) * (longint'(32768) - longint'(h))) >>> 13;
                d = (s * longint'(DUTY_SWING_DEF)) >>> 15;
                if (lfo_top[15])
                    d = -d;
                high = longint'({32'b0, osc_acc}) < (HALF_CYCLE - d);
                osc_acc = osc_acc + osc_inc;
                case (stage)
                    ST_ATTACK:
                    begin
                        if (atk_step == 0)
                        begin
                            env = FULL_SCALE;
                            stage = ST_DECAY;
                            lvl = FULL_SCALE;
                        end
                        else
                        begin
                            lvl = env;
                            env = env + atk_step;
                            if (env >= FULL_SCALE)
                            begin
                                env = FULL_SCALE;
                                stage = ST_DECAY;
                            end
                        end
                    end
                    ST_DECAY:
                    begin
                        if (dec_step == 0 || env <= sus_lvl + dec_step)
                        begin
                            env = sus_lvl;
                            stage = ST_SUSTAIN;
                        end
                        else
                            env = env - dec_step;
                        lvl = env;
                    end
                    ST_SUSTAIN:
                        lvl = env;
                    default:
                    begin
                        lvl = env;
                        if (env < env_drop)
                        begin
                            env = 0;
                            stage = ST_IDLE;
                        end
                        else
                            env = env - env_drop;
                    end
                endcase
                amp = (longint'(PULSE_AMPLITUDE_DEF & 32'h7FFF) * 4 * longint'(lvl)) >>> 15;
                if (!high)
                    amp = -amp;
                if (amp > 32767)
                    amp = 32767;
                if (amp < -32768)
                    amp = -32768;
                r.sample = amp[15:0];
                r.active = (stage != ST_IDLE);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int idle_len(inout int rush);
        int r;
        if (rush > 0)
        begin
            rush--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            rush = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag(input string what, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[pwm_pulse_voice_adsr] ERROR");
            $finish;
        end
        if (!rst_n)
        begin
            item_fire = 1'b0;
            atk_step = 0;
            dec_step = 0;
            sus_lvl = FULL_SCALE;
            rel_step = 0;
            osc_acc = '0;
            lfo_acc = '0;
            osc_inc = '0;
            env = 0;
            env_drop = 0;
            stage = ST_IDLE;
        end
        else
        begin
            item_fire = item_valid && item_ready;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATTACK:  atk_step = cfg_data;
                    CFG_DECAY:   dec_step = cfg_data;
                    CFG_SUSTAIN: sus_lvl = cfg_data;
                    CFG_RELEASE: rel_step = cfg_data;
                    default:     ;
                endcase
            end
            if (item_fire)
            begin
                words_taken++;
                if (voice_step(item, want))
                    expected_samples.insert(expected_samples.size(), want);
            end
            if (result_valid && result_ready)
            begin
                if (expected_samples.size() == 0)
                    flag("unexpected result word", 0, int'(result.sample));
                else
                begin
                    want = expected_samples.pop_front();
                    if (result.sample !== want.sample)
                        flag("sample", int'(want.sample), int'(result.sample));
                    if (result.active !== want.active)
                        flag("active", int'(want.active), int'(result.active));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_words.size() > 0)
            begin
                item <= pending_words.pop_front();
                item_valid <= 1'b1;
                send_gap = idle_len(send_rush);
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = idle_len(take_rush);
        end
    end

    task automatic push_word(input logic [1:0] op, input logic [31:0] step);
        item_t w;
        w.op = op;
        w.phase_step = step;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    task automatic settle();
        while (!(words_taken == words_queued && expected_samples.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input int unsigned atk, input int unsigned dec,
                             input int unsigned sus, input int unsigned rel);
        logic [CFG_IDX_W-1:0] idx [4];
        int unsigned          val [4];
        idx = '{CFG_ATTACK, CFG_DECAY, CFG_SUSTAIN, CFG_RELEASE};
        val = '{atk, dec, sus, rel};
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
        cfg_data <= REG_W'($urandom);
        @(negedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= REG_W'(val[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return FULL_SCALE;
            7, 8:    return $urandom_range(1, 800);
            9:       return $urandom_range(0, 32767);
            default: return $urandom_range(800, 9000);
        endcase
    endfunction

    function automatic int unsigned pick_level();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return FULL_SCALE;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic make_phase(input int n);
        int         made;
        int         k;
        logic [1:0] op;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                push_word(OP_NOTE_ON, pick_increment());
                k = $urandom_range(1, 30);
                repeat (k) push_word(OP_TICK, $urandom);
                made += k + 1;
                if ($urandom_range(0, 9) < 8)
                begin
                    push_word(OP_NOTE_OFF, $urandom);
                    made++;
                end
                k = $urandom_range(0, 12);
                repeat (k) push_word(OP_TICK, $urandom);
                made += k;
            end
            else
            begin
                op = 2'($urandom_range(0, 3));
                push_word(op, $urandom);
                if (op != OP_SPARE)
                    made++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '1);
        push_word(OP_SPARE, '1);
        push_word(OP_NOTE_ON, '0);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '0);
        push_word(OP_TICK, '0);
        settle();

        configure(FULL_SCALE, 0, 16384, FULL_SCALE);
        push_word(OP_NOTE_ON, '1);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '0);
        push_word(OP_TICK, '0);
        settle();

        configure(3000, FULL_SCALE, 0, 1);
        push_word(OP_NOTE_ON, 32'h8000_0000);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        settle();
        configure(0, FULL_SCALE, 0, 1);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '0);
        settle();

        configure(0, 100, 1000, FULL_SCALE);
        push_word(OP_NOTE_ON, 32'h1234_5678);
        push_word(OP_TICK, '0);
        settle();
        configure(0, 100, FULL_SCALE, FULL_SCALE);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_ON, 32'h4000_0000);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '0);
        push_word(OP_TICK, '0);
        push_word(OP_NOTE_OFF, '0);
        push_word(OP_TICK, '0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                configure(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
            else if (p == 1)
                configure(1, 1, 0, 1);
            else
                configure(pick_step(), pick_step(), pick_level(), pick_step());
            make_phase(RANDOM_WORDS / PHASES);
            settle();
        end

        if (error_count == 0)
            $display("[pwm_pulse_voice_adsr] OK");
        else
            $display("[pwm_pulse_voice_adsr] ERROR");
        $finish;
    end

endmodule
